// ----- rtl/ctb_pkg.sv -----
package ctb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int ACT_W      = 3;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int TICK_W     = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [CNT_W-1:0] ALLOC_MAX = CNT_W'(NUM_TIMERS);

    localparam logic [ACT_W-1:0] ACT_TICK     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REGISTER = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STOP     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PAUSE    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_WALK    = 4'b0010,
        S_STAT_RD = 4'b0100,
        S_EMIT    = 4'b1000
    } state_t;

endpackage

// ----- rtl/countdown_timer_bank_core.sv -----
// Sequence: a tick passes through S_WALK over the allocated timers, then S_STAT_RD
//   and S_EMIT; with no timer allocated it skips S_WALK. Every other action goes
//   from S_IDLE straight to S_STAT_RD and S_EMIT.
// Throughput: one item per result; the next item is taken once the result is loaded
//   into the output register. The tick walk through the count memory (one entry per
//   cycle, read and write-back overlapped) sets the tick cost.
// Reset: aresetn (synchronous, active low) clears the tick count, allocation count,
//   running flags and output valid; count memory entries are written on allocation.
module countdown_timer_bank_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action[2:0], timer_index[6:3], load_value[38:7], zero pad [39]
    input  logic [ctb_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // register_ok[0], new_index[4:1], is_on[5], is_done[6], tick_now[38:7], zero pad [39]
    output logic [ctb_pkg::M_TDATA_W-1:0]   m_tdata
);

    // Input field split
    logic [ctb_pkg::ACT_W-1:0]  in_act;
    logic [ctb_pkg::IDX_W-1:0]  in_idx;
    logic [ctb_pkg::TICK_W-1:0] in_load;

    assign in_act  = s_tdata[2:0];
    assign in_idx  = s_tdata[6:3];
    assign in_load = s_tdata[38:7];

    // Control state
    ctb_pkg::state_t                state_reg, state_next;
    logic [ctb_pkg::CNT_W-1:0]      alloc_reg, alloc_next;
    logic [ctb_pkg::TICK_W-1:0]     ticks_reg, ticks_next;
    logic [ctb_pkg::NUM_TIMERS-1:0] run_reg, run_next;
    logic [ctb_pkg::CNT_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic                           wb_valid_reg, wb_valid_next;
    logic                           m_tvalid_reg, m_tvalid_next;

    // Payload registers
    logic [ctb_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                           ok_reg, ok_next;
    logic [ctb_pkg::IDX_W-1:0]      newidx_reg, newidx_next;
    logic [ctb_pkg::IDX_W-1:0]      wb_addr_reg, wb_addr_next;
    logic [ctb_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Count memory: one write port, one registered read port
    logic [ctb_pkg::TICK_W-1:0]     cnt_mem [ctb_pkg::NUM_TIMERS];
    logic [ctb_pkg::TICK_W-1:0]     rdata_reg;
    logic                           run_rd_reg;
    logic                           mem_we;
    logic [ctb_pkg::IDX_W-1:0]      mem_waddr;
    logic [ctb_pkg::TICK_W-1:0]     mem_wdata;
    logic [ctb_pkg::IDX_W-1:0]      rd_addr;

    // Shared zero test and decrement on the memory read data
    logic                           cnt_zero;
    logic [ctb_pkg::TICK_W-1:0]     cnt_dec;

    logic                           in_valid;
    logic                           st_valid;
    logic                           walk_issue;
    logic                           st_on;
    logic                           st_done;

    assign cnt_zero   = (rdata_reg == '0);
    assign cnt_dec    = rdata_reg - ctb_pkg::TICK_W'(1);
    assign in_valid   = ({1'b0, in_idx} < alloc_reg);
    assign st_valid   = ({1'b0, idx_reg} < alloc_reg);
    assign walk_issue = (rd_ptr_reg < alloc_reg);
    assign st_on      = st_valid & run_rd_reg;
    assign st_done    = st_on & cnt_zero;

    assign s_tready = (state_reg == ctb_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        alloc_next    = alloc_reg;
        ticks_next    = ticks_reg;
        run_next      = run_reg;
        rd_ptr_next   = rd_ptr_reg;
        wb_valid_next = wb_valid_reg;
        m_tvalid_next = m_tvalid_reg;
        idx_next      = idx_reg;
        ok_next       = ok_reg;
        newidx_next   = newidx_reg;
        wb_addr_next  = wb_addr_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = in_idx;
        mem_wdata     = '0;
        rd_addr       = idx_reg;

        // Drop the result once the sink takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ctb_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    idx_next    = in_idx;
                    ok_next     = 1'b0;
                    newidx_next = '0;
                    state_next  = ctb_pkg::S_STAT_RD;
                    case (in_act)
                        ctb_pkg::ACT_TICK: begin
                            // Advance the shared count, then walk allocated timers
                            ticks_next    = ticks_reg + ctb_pkg::TICK_W'(1);
                            rd_ptr_next   = '0;
                            wb_valid_next = 1'b0;
                            if (alloc_reg != '0) begin
                                state_next = ctb_pkg::S_WALK;
                            end
                        end
                        ctb_pkg::ACT_REGISTER: begin
                            if (alloc_reg < ctb_pkg::ALLOC_MAX) begin
                                mem_we      = 1'b1;
                                mem_waddr   = alloc_reg[ctb_pkg::IDX_W-1:0];
                                mem_wdata   = '0;
                                ok_next     = 1'b1;
                                newidx_next = alloc_reg[ctb_pkg::IDX_W-1:0];
                                alloc_next  = alloc_reg + ctb_pkg::CNT_W'(1);
                            end
                        end
                        ctb_pkg::ACT_START: begin
                            if (in_valid) begin
                                run_next[in_idx] = 1'b1;
                                mem_we           = 1'b1;
                                mem_wdata        = in_load;
                            end
                        end
                        ctb_pkg::ACT_STOP: begin
                            if (in_valid) begin
                                run_next[in_idx] = 1'b0;
                                mem_we           = 1'b1;
                                mem_wdata        = '0;
                            end
                        end
                        ctb_pkg::ACT_PAUSE: begin
                            if (in_valid) begin
                                run_next[in_idx] = 1'b0;
                            end
                        end
                        default: begin
                            // Query and unused codes change nothing
                        end
                    endcase
                end
            end
            ctb_pkg::S_WALK: begin
                // Read entry rd_ptr while writing back the one read last cycle
                rd_addr = rd_ptr_reg[ctb_pkg::IDX_W-1:0];
                if (walk_issue) begin
                    rd_ptr_next   = rd_ptr_reg + ctb_pkg::CNT_W'(1);
                    wb_valid_next = 1'b1;
                    wb_addr_next  = rd_ptr_reg[ctb_pkg::IDX_W-1:0];
                end else begin
                    wb_valid_next = 1'b0;
                    state_next    = ctb_pkg::S_STAT_RD;
                end
                if (wb_valid_reg && run_rd_reg && !cnt_zero) begin
                    mem_we    = 1'b1;
                    mem_waddr = wb_addr_reg;
                    mem_wdata = cnt_dec;
                end
            end
            ctb_pkg::S_STAT_RD: begin
                // Fetch the addressed timer after all writes of this item
                state_next = ctb_pkg::S_EMIT;
            end
            ctb_pkg::S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {1'b0, ticks_reg, st_done, st_on, newidx_reg, ok_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ctb_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ctb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ctb_pkg::S_IDLE;
            alloc_reg    <= '0;
            ticks_reg    <= '0;
            run_reg      <= '0;
            rd_ptr_reg   <= '0;
            wb_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            alloc_reg    <= alloc_next;
            ticks_reg    <= ticks_next;
            run_reg      <= run_next;
            rd_ptr_reg   <= rd_ptr_next;
            wb_valid_reg <= wb_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        newidx_reg  <= newidx_next;
        wb_addr_reg <= wb_addr_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg  <= cnt_mem[rd_addr];
        run_rd_reg <= run_reg[rd_addr];
    end

    // Allocation never passes the bank size
    a_alloc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_reg <= ctb_pkg::ALLOC_MAX)
        else $error("allocation count beyond bank size");

    // The walk only runs over a nonempty bank and never passes its end
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ctb_pkg::S_WALK) |-> (alloc_reg != '0 && rd_ptr_reg <= alloc_reg))
        else $error("tick walk out of range");

    // A done timer is always reported on
    a_done_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (!m_tdata_reg[6] || m_tdata_reg[5]))
        else $error("done reported without on");

    // A granted index is always among the allocated timers
    a_grant_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[0]) |-> ({1'b0, m_tdata_reg[4:1]} < alloc_reg))
        else $error("granted index not allocated");

    // A write-back pending in the walk targets the entry just behind the read pointer
    a_wb_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ctb_pkg::S_WALK && wb_valid_reg)
            |-> ({1'b0, wb_addr_reg} + ctb_pkg::CNT_W'(1) == rd_ptr_reg))
        else $error("write-back address out of step");

endmodule

// ----- dv/countdown_timer_bank_core_tb.sv -----
module countdown_timer_bank_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Action codes that the package leaves unnamed
    localparam logic [ctb_pkg::ACT_W-1:0] ACT_QUERY = 3'd5;
    localparam logic [ctb_pkg::ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ctb_pkg::ACT_W-1:0] ACT_RSVD7 = 3'd7;

    // A tick walks every allocated timer
    localparam int DRAIN_CYCLES = ctb_pkg::NUM_TIMERS + 16;
    // Longest receiver hold-off in the backpressure test
    localparam int HOLD_CYCLES  = 300;
    // Cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        logic                       register_ok;
        logic [ctb_pkg::IDX_W-1:0]  new_index;
        logic                       is_on;
        logic                       is_done;
        logic [ctb_pkg::TICK_W-1:0] tick_now;
    } timer_report_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ctb_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ctb_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the timer bank, advanced once per accepted item
    logic [ctb_pkg::TICK_W-1:0] tick_count = '0;
    int                         timers_used = 0;
    logic                       timer_running [ctb_pkg::NUM_TIMERS];
    logic [ctb_pkg::TICK_W-1:0] timer_left    [ctb_pkg::NUM_TIMERS];

    timer_report_t pending_reports[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          stall_cycles = 0;
    int          error_count = 0;

    countdown_timer_bank_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        for (int k = 0; k < ctb_pkg::NUM_TIMERS; k++) begin
            timer_running[k] = 1'b0;
            timer_left[k]    = '0;
        end
    end

    // Apply one action to the shadow bank and return the report it should produce.
    // Start, stop and pause act only on allocated timers; the status fields always
    // describe the timer named by the index, even for tick and register.
    function automatic timer_report_t apply_action(
        input logic [ctb_pkg::ACT_W-1:0]  act,
        input logic [ctb_pkg::IDX_W-1:0]  idx,
        input logic [ctb_pkg::TICK_W-1:0] load);
        timer_report_t rpt;
        logic          addressed;
        rpt = '{default: '0};
        addressed = (int'(idx) < timers_used);
        case (act)
            ctb_pkg::ACT_TICK: begin
                tick_count = tick_count + ctb_pkg::TICK_W'(1);
                // Decrement running timers, holding at zero
                for (int k = 0; k < timers_used; k++) begin
                    if (timer_running[k] && timer_left[k] != '0) begin
                        timer_left[k] = timer_left[k] - ctb_pkg::TICK_W'(1);
                    end
                end
            end
            ctb_pkg::ACT_REGISTER: begin
                // A full bank refuses the request and reports index zero
                if (timers_used < ctb_pkg::NUM_TIMERS) begin
                    timer_left[timers_used] = '0;
                    rpt.new_index   = ctb_pkg::IDX_W'(timers_used);
                    rpt.register_ok = 1'b1;
                    timers_used++;
                end
            end
            ctb_pkg::ACT_START: begin
                if (addressed) begin
                    timer_running[idx] = 1'b1;
                    timer_left[idx]    = load;
                end
            end
            ctb_pkg::ACT_STOP: begin
                if (addressed) begin
                    timer_running[idx] = 1'b0;
                    timer_left[idx]    = '0;
                end
            end
            ctb_pkg::ACT_PAUSE: begin
                if (addressed) begin
                    timer_running[idx] = 1'b0;
                end
            end
            default: begin
                // Query and the two spare codes leave the bank untouched
            end
        endcase
        if (int'(idx) < timers_used) begin
            rpt.is_on   = timer_running[idx];
            rpt.is_done = timer_running[idx] && (timer_left[idx] == '0);
        end
        rpt.tick_now = tick_count;
        return rpt;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [ctb_pkg::TICK_W-1:0] want,
                                        input logic [ctb_pkg::TICK_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Predict at the input handshake, so queue order follows accept order
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            pending_reports.push_back(apply_action(s_tdata[2:0], s_tdata[6:3],
                                                   s_tdata[38:7]));
        end
    end

    // Compare every accepted report with the oldest prediction
    always @(posedge aclk) begin : report_check
        timer_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected report: tdata %h with nothing pending", m_tdata);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("register_ok", ctb_pkg::TICK_W'(want.register_ok),
                            ctb_pkg::TICK_W'(m_tdata[0]));
                check_field("new_index", ctb_pkg::TICK_W'(want.new_index),
                            ctb_pkg::TICK_W'(m_tdata[4:1]));
                check_field("is_on", ctb_pkg::TICK_W'(want.is_on),
                            ctb_pkg::TICK_W'(m_tdata[5]));
                check_field("is_done", ctb_pkg::TICK_W'(want.is_done),
                            ctb_pkg::TICK_W'(m_tdata[6]));
                check_field("tick_now", want.tick_now, m_tdata[38:7]);
            end
        end
    end

    // Drive m_tready: a requested long hold-off first, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // End the run if neither side moves an item for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one item and hold it until accepted. Keep tvalid high between
    // back-to-back items; drop it only when a random gap is taken.
    task automatic send_item(input logic [ctb_pkg::ACT_W-1:0]  act,
                             input logic [ctb_pkg::IDX_W-1:0]  idx,
                             input logic [ctb_pkg::TICK_W-1:0] load);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, load, idx, act};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Build one random item, biased toward allocated timers and short loads so
    // that countdowns actually reach zero.
    task automatic send_random_item();
        logic [ctb_pkg::ACT_W-1:0]  act;
        logic [ctb_pkg::IDX_W-1:0]  idx;
        logic [ctb_pkg::TICK_W-1:0] load;
        int unsigned                pick;
        pick = $urandom_range(99);
        if (pick < 35)      act = ctb_pkg::ACT_TICK;
        else if (pick < 40) act = ctb_pkg::ACT_REGISTER;
        else if (pick < 60) act = ctb_pkg::ACT_START;
        else if (pick < 68) act = ctb_pkg::ACT_STOP;
        else if (pick < 76) act = ctb_pkg::ACT_PAUSE;
        else if (pick < 94) act = ACT_QUERY;
        else                act = $urandom_range(1) ? ACT_RSVD7 : ACT_RSVD6;
        if (timers_used > 0 && $urandom_range(9) < 8) begin
            idx = ctb_pkg::IDX_W'($urandom_range(timers_used - 1));
        end else begin
            idx = ctb_pkg::IDX_W'($urandom_range(ctb_pkg::NUM_TIMERS - 1));
        end
        pick = $urandom_range(9);
        if (pick < 6)       load = $urandom_range(12);
        else if (pick < 8)  load = $urandom;
        else if (pick == 8) load = '0;
        else                load = '1;
        send_item(act, idx, load);
    endtask

    // Start, stop, pause, query and tick on an empty bank: no timer changes, status reads zero
    task automatic test_unallocated();
        send_item(ctb_pkg::ACT_START, 4'd0, 32'd5);
        send_item(ctb_pkg::ACT_STOP, 4'd3, 32'd0);
        send_item(ctb_pkg::ACT_PAUSE, 4'd15, 32'hFFFF_FFFF);
        send_item(ACT_QUERY, 4'd0, 32'd0);
        send_item(ctb_pkg::ACT_TICK, 4'd7, 32'd0);
    endtask

    // Allocate three timers and take them through start, countdown, pause and stop
    task automatic test_timer_lifecycle();
        send_item(ctb_pkg::ACT_REGISTER, 4'd0, 32'd0);
        send_item(ctb_pkg::ACT_REGISTER, 4'd0, 32'd0);
        send_item(ctb_pkg::ACT_REGISTER, 4'd15, 32'd0);
        send_item(ctb_pkg::ACT_START, 4'd0, 32'd2);
        // Zero load reads done right away
        send_item(ctb_pkg::ACT_START, 4'd1, 32'd0);
        send_item(ctb_pkg::ACT_START, 4'd2, 32'hFFFF_FFFF);
        send_item(ctb_pkg::ACT_TICK, 4'd0, 32'd0);
        send_item(ctb_pkg::ACT_TICK, 4'd0, 32'd0);
        // Hold at zero and stay done on further ticks
        send_item(ctb_pkg::ACT_TICK, 4'd0, 32'd0);
        send_item(ctb_pkg::ACT_PAUSE, 4'd0, 32'd0);
        send_item(ctb_pkg::ACT_TICK, 4'd2, 32'd0);
        send_item(ctb_pkg::ACT_START, 4'd0, 32'd1);
        send_item(ctb_pkg::ACT_STOP, 4'd2, 32'd0);
        send_item(ACT_QUERY, 4'd2, 32'd0);
        send_item(ctb_pkg::ACT_PAUSE, 4'd1, 32'd0);
        // Index just past the allocated range
        send_item(ctb_pkg::ACT_START, 4'd3, 32'd9);
    endtask

    // Spare action codes behave as a query
    task automatic test_spare_actions();
        send_item(ACT_RSVD6, 4'd0, $urandom);
        send_item(ACT_RSVD7, 4'd15, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_mix(input int count, input int unsigned send_pct,
                                   input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_random_item();
    endtask

    // Stall the output for a long stretch while items keep coming, so the
    // block fills and drops s_tready
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (24) send_random_item();
    endtask

    // Fill whatever is left of the bank, then try to register past the end
    task automatic test_bank_full();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        repeat (ctb_pkg::NUM_TIMERS + 2) begin
            send_item(ctb_pkg::ACT_REGISTER,
                      ctb_pkg::IDX_W'($urandom_range(ctb_pkg::NUM_TIMERS - 1)), '0);
        end
        send_item(ctb_pkg::ACT_START, 4'd15, 32'd1);
        send_item(ctb_pkg::ACT_TICK, 4'd15, 32'd0);
        send_item(ACT_QUERY, 4'd15, 32'd0);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_unallocated();
        test_timer_lifecycle();
        test_spare_actions();
        test_random_mix(330, 21, 51);
        test_random_mix(330, 51, 21);
        test_random_mix(330, 0, 0);
        test_output_backpressure();
        test_bank_full();

        // Drop valid, drain pending reports, then watch for stray ones
        s_tvalid <= 1'b0;
        recv_idle_pct = 0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
